FILE: rtl/mono_framebuffer_page_transposer_macros.svh
// Assertion macros used by the checker file of the frame page transposer.
`ifndef MONO_FRAMEBUFFER_PAGE_TRANSPOSER_MACROS_SVH
`define MONO_FRAMEBUFFER_PAGE_TRANSPOSER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define MFPT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, off while reset is high.
`define MFPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define MFPT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/mfpt_pkg.sv
// Shared constants and types of the frame page transposer.
`timescale 1ns / 1ps
`default_nettype none

package mfpt_pkg;

   localparam int COLUMNS    = 128;
   localparam int PAGES      = 8;
   localparam int ROW_BYTES  = COLUMNS / 8;
   localparam int BANKS      = 8;
   localparam int BANK_DEPTH = PAGES * ROW_BYTES;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CMD_PAGE_BASE    = 8'hB0;
   localparam logic [7:0] CMD_COLUMN_UPPER = 8'h10;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_COLUMN = 1'b1;

   localparam logic CSR_MIRROR_X = 1'b0;
   localparam logic CSR_MIRROR_Y = 1'b1;

   // One column item after its memory read.
   typedef struct packed {
      logic [2:0] page;
      logic       first_col;
      logic [7:0] pix;
   } col_entry_type;

   typedef struct packed {
      logic          valid;
      col_entry_type entry;
   } col_push_type;

   typedef struct packed {
      logic [FIFO_CW-1:0] count;
      logic               not_empty;
   } fifo_status_type;

endpackage

`default_nettype wire

FILE: rtl/mono_framebuffer_page_transposer.sv
// Top level of the monochrome frame buffer to LCD page/column transposer.
`timescale 1ns / 1ps
`default_nettype none

// Holds a 128x64 one-bit frame, row-major, 16 bytes per row, bit 0 leftmost.
// An item is taken at a clock edge with start high and busy low. A write item
// (req_op = 0) stores req_frame_data at req_frame_address in that cycle and
// gives no result. A column item (req_op = 1) gives the LCD byte of display
// column req_column of page req_page (bit k = row k of the page), preceded on
// column 0 by the set-page and set-column-upper commands with rsp_is_data low.
// Results cannot be stalled: each shows on the rsp_ ports for exactly one
// cycle with rsp_strobe high, and rsp_last marks the final one of an item.
// The frame sits in eight byte-wide banks, one per row of a page, so all
// eight rows of a column are read at once. The first result of a column item
// passes the bank read and stage-1 registers, a queue slot and the sequencer
// state register. The output sequencer sets the sustained rate: one column
// item per cycle for columns other than 0, while the queue holds items. A
// four-entry queue sits between the memory read and the sequencer, and busy
// is high while it (counting a read still in flight) is full. The user must
// write the mirror registers through the csr_ port only while no item is in
// flight; the block does not enforce this. Index 0 is mirror X, index 1
// mirror Y. Unwritten frame bytes read back as whatever the memory holds.

module mono_framebuffer_page_transposer (
   input  wire logic       clock,
   input  wire logic       reset,
   // item channel
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_op,
   input  wire logic [9:0] req_frame_address,
   input  wire logic [7:0] req_frame_data,
   input  wire logic [2:0] req_page,
   input  wire logic [6:0] req_column,
   // result channel
   output logic            rsp_strobe,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_last,
   // register writes
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic       csr_wdata
);

   logic mirror_x_ff;
   logic mirror_y_ff;

   mfpt_pkg::col_push_type    push;
   mfpt_pkg::col_entry_type   head;
   mfpt_pkg::fifo_status_type fifo_status;
   logic                      pop;

   // mirror registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mirror_x_ff <= 1'b0;
         mirror_y_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mfpt_pkg::CSR_MIRROR_X: begin
               mirror_x_ff <= csr_wdata;
            end
            mfpt_pkg::CSR_MIRROR_Y: begin
               mirror_y_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // accept, frame banks, column byte gather
   mfpt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .op           (req_op),
      .frame_address(req_frame_address),
      .frame_data   (req_frame_data),
      .page         (req_page),
      .column       (req_column),
      .mirror_x     (mirror_x_ff),
      .mirror_y     (mirror_y_ff),
      .fifo_status  (fifo_status),
      .push         (push)
   );

   // decoupling queue
   mfpt_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .status(fifo_status)
   );

   // result sequencer
   mfpt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .head        (head),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_data (rsp_is_data),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

FILE: rtl/mfpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mfpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/mfpt_front.sv
// Front end: item accept, banked frame store and column byte assembly.
`timescale 1ns / 1ps
`default_nettype none

module mfpt_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic                     op,
   input  wire logic [9:0]               frame_address,
   input  wire logic [7:0]               frame_data,
   input  wire logic [2:0]               page,
   input  wire logic [6:0]               column,
   input  wire logic                     mirror_x,
   input  wire logic                     mirror_y,
   input  wire mfpt_pkg::fifo_status_type fifo_status,
   output mfpt_pkg::col_push_type        push
);

   logic                         accept;
   logic                         wr_en;
   logic                         rd_en;
   logic [2:0]                   wr_bank;
   logic [mfpt_pkg::BANK_AW-1:0] wr_addr;
   logic [6:0]                   src_col;
   logic [2:0]                   rd_block;
   logic [mfpt_pkg::BANK_AW-1:0] rd_addr;
   logic [7:0]                   rdata [mfpt_pkg::BANKS];
   logic [7:0]                   pix;
   logic [mfpt_pkg::FIFO_CW:0]   pending;

   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_page_ff;
   logic       s1_first_ff;
   logic [2:0] s1_bit_ff;
   logic       s1_mirror_y_ff;

   // Space check counts the item whose read is still in flight.
   assign pending = {1'b0, fifo_status.count} + {{mfpt_pkg::FIFO_CW{1'b0}}, s1_valid_ff};
   assign busy    = pending >= (mfpt_pkg::FIFO_CW + 1)'(mfpt_pkg::FIFO_DEPTH);
   assign accept  = start && !busy;
   assign wr_en   = accept && (op == mfpt_pkg::OP_WRITE);
   assign rd_en   = accept && (op == mfpt_pkg::OP_COLUMN);

   // Bank is frame row mod 8; bank word is row block and byte in row.
   assign wr_bank = frame_address[6:4];
   assign wr_addr = {frame_address[9:7], frame_address[3:0]};

   assign src_col  = mirror_x ? ~column : column;
   assign rd_block = mirror_y ? ~page : page;
   assign rd_addr  = {rd_block, src_col[6:3]};

   for (genvar b = 0; b < mfpt_pkg::BANKS; b++) begin : g_bank
      mfpt_ram #(
         .WIDTH(8),
         .DEPTH(mfpt_pkg::BANK_DEPTH)
      ) u_bank (
         .clock(clock),
         .we   (wr_en && (wr_bank == 3'(b))),
         .waddr(wr_addr),
         .wdata(frame_data),
         .re   (rd_en),
         .raddr(rd_addr),
         .rdata(rdata[b])
      );
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (s1_mirror_y_ff) begin
            pix[k] = rdata[3'(7 - k)][s1_bit_ff];
         end else begin
            pix[k] = rdata[3'(k)][s1_bit_ff];
         end
      end
   end

   assign s1_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_page_ff     <= page;
         s1_first_ff    <= (column == 7'd0);
         s1_bit_ff      <= src_col[2:0];
         s1_mirror_y_ff <= mirror_y;
      end
   end

   assign push.valid           = s1_valid_ff;
   assign push.entry.page      = s1_page_ff;
   assign push.entry.first_col = s1_first_ff;
   assign push.entry.pix       = pix;

endmodule

`default_nettype wire

FILE: rtl/mfpt_fifo.sv
// Short queue of assembled column items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mfpt_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mfpt_pkg::col_push_type    push,
   input  wire logic                      pop,
   output mfpt_pkg::col_entry_type        head,
   output mfpt_pkg::fifo_status_type      status
);

   mfpt_pkg::col_entry_type      slot_ff [mfpt_pkg::FIFO_DEPTH];
   logic [mfpt_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mfpt_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mfpt_pkg::FIFO_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

endmodule

`default_nettype wire

FILE: rtl/mfpt_back.sv
// Back end: emits the command bytes of column-0 items and the column byte of each item.
`timescale 1ns / 1ps
`default_nettype none

module mfpt_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mfpt_pkg::fifo_status_type fifo_status,
   input  wire mfpt_pkg::col_entry_type   head,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_is_data,
   output logic                           rsp_last
);

   typedef enum logic [3:0] {
      BK_IDLE  = 4'b0001,
      BK_PAGE  = 4'b0010,
      BK_UPPER = 4'b0100,
      BK_DATA  = 4'b1000
   } back_state_type;

   back_state_type          state_ff, state_in;
   mfpt_pkg::col_entry_type cur_ff;

   // A new item loads when nothing is shown or the data byte is shown.
   assign pop = ((state_ff == BK_IDLE) || (state_ff == BK_DATA)) && fifo_status.not_empty;

   always_comb begin
      case (state_ff)
         BK_PAGE: begin
            state_in = BK_UPPER;
         end
         BK_UPPER: begin
            state_in = BK_DATA;
         end
         BK_IDLE, BK_DATA: begin
            if (fifo_status.not_empty) begin
               state_in = head.first_col ? BK_PAGE : BK_DATA;
            end else begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   always_comb begin
      case (state_ff)
         BK_PAGE: begin
            rsp_strobe   = 1'b1;
            rsp_out_byte = mfpt_pkg::CMD_PAGE_BASE | {5'd0, cur_ff.page};
            rsp_is_data  = 1'b0;
            rsp_last     = 1'b0;
         end
         BK_UPPER: begin
            rsp_strobe   = 1'b1;
            rsp_out_byte = mfpt_pkg::CMD_COLUMN_UPPER;
            rsp_is_data  = 1'b0;
            rsp_last     = 1'b0;
         end
         BK_DATA: begin
            rsp_strobe   = 1'b1;
            rsp_out_byte = cur_ff.pix;
            rsp_is_data  = 1'b1;
            rsp_last     = 1'b1;
         end
         default: begin
            rsp_strobe   = 1'b0;
            rsp_out_byte = 8'd0;
            rsp_is_data  = 1'b0;
            rsp_last     = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/mfpt_checker.sv
// Port-level checks of the frame page transposer and their bind.
`timescale 1ns / 1ps
`default_nettype none

`include "mono_framebuffer_page_transposer_macros.svh"

module mfpt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_strobe,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_data,
   input wire logic       rsp_last
);

   logic page_cmd;
   logic upper_cmd;

   assign page_cmd  = rsp_strobe && !rsp_is_data && (rsp_out_byte[7:4] == 4'hB);
   assign upper_cmd = rsp_strobe && !rsp_is_data && (rsp_out_byte == 8'h10);

   `MFPT_ASSERT_NEXT_ALWAYS(a_quiet_after_reset, clock, reset, !rsp_strobe)
   `MFPT_ASSERT_NEXT(a_page_then_upper, clock, reset, page_cmd, upper_cmd)
   `MFPT_ASSERT_NEXT(a_upper_then_data, clock, reset, upper_cmd, rsp_strobe && rsp_is_data && rsp_last)
   `MFPT_ASSERT_IMPLIES(a_data_is_last, clock, reset, rsp_strobe && rsp_is_data, rsp_last)

endmodule

bind mono_framebuffer_page_transposer mfpt_checker u_mfpt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_strobe  (rsp_strobe),
   .rsp_out_byte(rsp_out_byte),
   .rsp_is_data (rsp_is_data),
   .rsp_last    (rsp_last)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the monochrome frame buffer page/column transposer.
`timescale 1ns / 1ps

// One result of the block, as seen on the rsp_ ports.
typedef struct packed {
   logic [7:0] out_byte;
   logic       is_data;
   logic       last;
} lcd_result_type;

// Keeps its own copy of the frame and the mirror bits, predicts the LCD bytes
// of every accepted column item and compares them with what comes out.
class lcd_column_checker;
   logic [7:0]     frame_copy [0:1023];
   bit             mirror_x;
   bit             mirror_y;
   lcd_result_type expected_bytes [$];
   int             mismatch_count;

   function new();
      mirror_x = 1'b0;
      mirror_y = 1'b0;
      mismatch_count = 0;
   endfunction

   function void note_mirror(logic idx, logic val);
      if (idx == mfpt_pkg::CSR_MIRROR_X) mirror_x = val;
      else mirror_y = val;
   endfunction

   // Accepted item: writes go to the frame copy, column items queue results.
   function void note_item(logic op, logic [9:0] addr, logic [7:0] data,
                           logic [2:0] pg, logic [6:0] col);
      int             src_col;
      int             row;
      logic [7:0]     pix;
      lcd_result_type res;
      if (op == mfpt_pkg::OP_WRITE) begin
         frame_copy[addr] = data;
         return;
      end
      src_col = mirror_x ? (mfpt_pkg::COLUMNS - 1 - int'(col)) : int'(col);
      for (int k = 0; k < 8; k++) begin
         row = mirror_y ? ((mfpt_pkg::PAGES - 1 - int'(pg)) * 8 + (7 - k))
                        : (int'(pg) * 8 + k);
         pix[k] = frame_copy[row * mfpt_pkg::ROW_BYTES + src_col / 8][src_col % 8];
      end
      if (col == 7'd0) begin
         res.out_byte = mfpt_pkg::CMD_PAGE_BASE | {5'd0, pg};
         res.is_data  = 1'b0;
         res.last     = 1'b0;
         expected_bytes.push_back(res);
         res.out_byte = mfpt_pkg::CMD_COLUMN_UPPER;
         expected_bytes.push_back(res);
      end
      res.out_byte = pix;
      res.is_data  = 1'b1;
      res.last     = 1'b1;
      expected_bytes.push_back(res);
   endfunction

   function void check_result(logic [7:0] out_byte, logic is_data, logic last);
      lcd_result_type want;
      if (expected_bytes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: byte %h is_data %b last %b",
                     out_byte, is_data, last);
         return;
      end
      want = expected_bytes.pop_front();
      if (want.out_byte !== out_byte || want.is_data !== is_data || want.last !== last) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch: expected byte %h is_data %b last %b, got %h %b %b",
                     want.out_byte, want.is_data, want.last, out_byte, is_data, last);
      end
   endfunction
endclass

module tb;

   localparam int DRAIN_CYCLES = 12;    // covers the bank read path plus the queue
   localparam int STALL_LIMIT  = 1000;  // cycles without any accepted item or result
   localparam int PHASE_ITEMS  = 100;   // items per random phase, fill writes included

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_op;
   logic [9:0] req_frame_address;
   logic [7:0] req_frame_data;
   logic [2:0] req_page;
   logic [6:0] req_column;
   logic       rsp_strobe;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_data;
   logic       rsp_last;
   logic       csr_we;
   logic       csr_index;
   logic       csr_wdata;

   lcd_column_checker lcd_check;

   // Stimulus-side view: which frame bytes hold data, and the mirror setting,
   // so that no column item ever reads a byte that was never written.
   bit written_mask [0:1023];
   bit mirror_x_now;
   bit mirror_y_now;
   bit idling_on;
   int stall_cycles;
   int items_sent;

   mono_framebuffer_page_transposer dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_frame_address (req_frame_address),
      .req_frame_data    (req_frame_data),
      .req_page          (req_page),
      .req_column        (req_column),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_data       (rsp_is_data),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Monitor: everything is sampled at the rising edge, before the NBA updates.
   // Results are checked ahead of new items; the queue keeps them in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) lcd_check.note_mirror(csr_index, csr_wdata);
         if (rsp_strobe) lcd_check.check_result(rsp_out_byte, rsp_is_data, rsp_last);
         if (start && !busy)
            lcd_check.note_item(req_op, req_frame_address, req_frame_data,
                                req_page, req_column);
      end
   end

   // Watchdog: a stuck busy or a lost result shows up as a long quiet spell.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Present one item and hold it until the block takes it. Returns at the
   // accepting edge with start still high, unless a random gap follows.
   task automatic send_item(input logic op, input logic [9:0] addr, input logic [7:0] data,
                            input logic [2:0] pg, input logic [6:0] col);
      items_sent++;
      req_op            <= op;
      req_frame_address <= addr;
      req_frame_data    <= data;
      req_page          <= pg;
      req_column        <= col;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      if (idling_on && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Page and column fields are don't-care on writes; keep them random.
   task automatic send_write(input logic [9:0] addr, input logic [7:0] data);
      written_mask[addr] = 1'b1;
      send_item(mfpt_pkg::OP_WRITE, addr, data, 3'($urandom), 7'($urandom));
   endtask

   // Column item; first fills any of its eight source bytes not yet written,
   // taking the current mirror setting into account.
   task automatic send_column(input logic [2:0] pg, input logic [6:0] col);
      int band;
      int src_col;
      int addr;
      band    = mirror_y_now ? (mfpt_pkg::PAGES - 1 - int'(pg)) : int'(pg);
      src_col = mirror_x_now ? (mfpt_pkg::COLUMNS - 1 - int'(col)) : int'(col);
      for (int r = 0; r < 8; r++) begin
         addr = (band * 8 + r) * mfpt_pkg::ROW_BYTES + src_col / 8;
         if (!written_mask[addr]) send_write(10'(addr), 8'($urandom));
      end
      send_item(mfpt_pkg::OP_COLUMN, 10'($urandom), 8'($urandom), pg, col);
   endtask

   // Stop sending, let every expected result come out, then wait DRAIN_CYCLES.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (lcd_check.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called while idle; both registers are written each time.
   task automatic set_mirrors(input bit mx, input bit my);
      csr_we    <= 1'b1;
      csr_index <= mfpt_pkg::CSR_MIRROR_X;
      csr_wdata <= mx;
      @(posedge clock);
      csr_index <= mfpt_pkg::CSR_MIRROR_Y;
      csr_wdata <= my;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror_x_now = mx;
      mirror_y_now = my;
   endtask

   initial begin
      bit         phase_mx [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
      bit         phase_my [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
      logic [7:0] patterns [8] = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFF, 8'h00};
      int         phase_base;
      bit         held;
      logic [6:0] col;

      lcd_check = new();
      idling_on = 1'b1;
      items_sent = 0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_op            <= mfpt_pkg::OP_WRITE;
      req_frame_address <= '0;
      req_frame_data    <= '0;
      req_page          <= '0;
      req_column        <= '0;
      csr_we            <= 1'b0;
      csr_index         <= mfpt_pkg::CSR_MIRROR_X;
      csr_wdata         <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: top-left and bottom-right corners, no mirroring.
      set_mirrors(1'b0, 1'b0);
      for (int r = 0; r < 8; r++) send_write(10'(r * mfpt_pkg::ROW_BYTES), patterns[r]);
      send_column(3'd0, 7'd0);      // column 0: page and column commands first
      send_column(3'd0, 7'd7);
      for (int r = 0; r < 8; r++)
         send_write(10'((56 + r) * mfpt_pkg::ROW_BYTES + 15), ~patterns[r]);   // ends at 1023
      send_column(3'd7, 7'd127);
      send_column(3'd7, 7'd120);
      settle();

      // Random phases over every mirror setting; the third runs without gaps.
      for (int ph = 0; ph < 4; ph++) begin
         set_mirrors(phase_mx[ph], phase_my[ph]);
         idling_on  = (ph != 2);
         phase_base = items_sent;
         held       = 1'b0;
         while (items_sent - phase_base < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 30) begin
               send_write(10'($urandom), 8'($urandom));
            end else begin
               col = ($urandom_range(0, 99) < 20) ? 7'd0 : 7'($urandom_range(0, 127));
               send_column(3'($urandom_range(0, 7)), col);
            end
            if (ph == 0 && !held && items_sent - phase_base >= PHASE_ITEMS / 2) begin
               settle();   // sender holds off mid-run
               held = 1'b1;
            end
         end
         settle();
      end

      if (lcd_check.expected_bytes.size() != 0) begin
         $display("%0d expected results never arrived", lcd_check.expected_bytes.size());
         lcd_check.mismatch_count += lcd_check.expected_bytes.size();
      end
      if (lcd_check.mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/mfpt_pkg.sv
rtl/mfpt_ram.sv
rtl/mfpt_front.sv
rtl/mfpt_fifo.sv
rtl/mfpt_back.sv
rtl/mono_framebuffer_page_transposer.sv
rtl/mfpt_checker.sv
verif/tb.sv
